@@ rtl/core/tlba_pkg.sv @@
// Shared types and constants for the two-level bitmap handle allocator.
`default_nettype none

package tlba_pkg;

    localparam int VALUE_W   = 13;
    localparam int HANDLE_W  = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_HANDLE_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PENDING_LIMIT = 1'b1;

    localparam logic [VALUE_W-1:0] LIMIT_RESET = 13'd1024;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_PENDING_LIMIT = 2'd1,
        STATUS_NO_FREE       = 2'd2,
        STATUS_NO_HANDLE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_GROUP,
        S_WORD
    } state_t;

    typedef struct packed {
        logic    clear_row;
        logic    load;
        logic    release_item;
        logic    grant;
        logic    use_scan;
        logic    next_group;
        logic    fetch_word;
        logic    reject;
        status_t reject_code;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_release;
        logic limit_hit;
        logic hint_ok;
        logic group_out;
        logic group_full;
        logic word_out;
        logic word_full;
        logic over_limit;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/two_level_bitmap_handle_allocator_unit.sv @@
// Top level of the two-level bitmap handle allocator.
`default_nettype none

// Hands out and takes back numeric handles tracked in a used-handle bitmap with a
// summary bitmap of full words. Pulse start while busy is low to issue one item;
// its result appears on granted_handle, status and in_use_count for exactly one
// cycle with done high, and must be captured then because the receiver cannot stall.
// After reset the block sweeps both bitmap memories clear, one bitmap word per cycle,
// and busy stays high until the sweep ends, before the first item is taken.
// A release, an allocate refused at the pending limit and an allocate that takes the
// hint handle end in the evaluate step after the load; a scanning allocate goes on
// to the group step, repeated per full summary group skipped, where it may fail, then
// to the word step. The single read port of the bitmap memory sets this order, read
// once for the hint word and once for the chosen word. cfg_ready is always high; the
// user writes limits through the cfg port only while the block is idle, unenforced.
module two_level_bitmap_handle_allocator_unit
#(
    parameter int CAPACITY  = 4096,
    parameter int WORD_BITS = 64
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           operation,
    input  wire logic [tlba_pkg::HANDLE_W-1:0]  handle,
    output logic                                done,
    output logic [tlba_pkg::HANDLE_W-1:0]       granted_handle,
    output logic [1:0]                          status,
    output logic [tlba_pkg::VALUE_W-1:0]        in_use_count,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tlba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tlba_pkg::VALUE_W-1:0]   cfg_data
);

    tlba_pkg::cmd_t  cmd;
    tlba_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    tlba_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    tlba_dp
    #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .operation      (operation),
        .handle         (handle),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .granted_handle (granted_handle),
        .status         (status),
        .in_use_count   (in_use_count)
    );

endmodule

`default_nettype wire

@@ rtl/core/tlba_ctrl.sv @@
// Controller state machine that sequences clearing, lookup, scan and commit.
`default_nettype none

module tlba_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire tlba_pkg::stat_t stat,
    output tlba_pkg::cmd_t      cmd
);

    tlba_pkg::state_t state_reg;
    tlba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlba_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != tlba_pkg::S_IDLE);
        case (state_reg)
            tlba_pkg::S_CLEAR:
            begin
                cmd.clear_row = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = tlba_pkg::S_IDLE;
                end
            end
            tlba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = tlba_pkg::S_EVAL;
                end
            end
            tlba_pkg::S_EVAL:
            begin
                if (stat.is_release)
                begin
                    cmd.release_item = 1'b1;
                    state_next       = tlba_pkg::S_IDLE;
                end
                else if (stat.limit_hit)
                begin
                    cmd.reject      = 1'b1;
                    cmd.reject_code = tlba_pkg::STATUS_PENDING_LIMIT;
                    state_next      = tlba_pkg::S_IDLE;
                end
                else if (stat.hint_ok)
                begin
                    cmd.grant  = 1'b1;
                    state_next = tlba_pkg::S_IDLE;
                end
                else
                begin
                    state_next = tlba_pkg::S_GROUP;
                end
            end
            tlba_pkg::S_GROUP:
            begin
                if (stat.group_out)
                begin
                    cmd.reject      = 1'b1;
                    cmd.reject_code = tlba_pkg::STATUS_NO_FREE;
                    state_next      = tlba_pkg::S_IDLE;
                end
                else if (stat.group_full)
                begin
                    cmd.next_group = 1'b1;
                end
                else if (stat.word_out)
                begin
                    cmd.reject      = 1'b1;
                    cmd.reject_code = tlba_pkg::STATUS_NO_FREE;
                    state_next      = tlba_pkg::S_IDLE;
                end
                else
                begin
                    cmd.fetch_word = 1'b1;
                    state_next     = tlba_pkg::S_WORD;
                end
            end
            tlba_pkg::S_WORD:
            begin
                if (stat.word_full || stat.over_limit)
                begin
                    cmd.reject      = 1'b1;
                    cmd.reject_code = tlba_pkg::STATUS_NO_FREE;
                end
                else
                begin
                    cmd.grant    = 1'b1;
                    cmd.use_scan = 1'b1;
                end
                state_next = tlba_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tlba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/tlba_dp.sv @@
// Datapath with the bitmap and summary memories, limits, hint, count and result registers.
`default_nettype none

module tlba_dp
#(
    parameter int CAPACITY  = 4096,
    parameter int WORD_BITS = 64
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tlba_pkg::cmd_t                     cmd,
    output tlba_pkg::stat_t                         stat,
    input  wire logic                               operation,
    input  wire logic [tlba_pkg::HANDLE_W-1:0]      handle,
    input  wire logic                               cfg_we,
    input  wire logic [tlba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tlba_pkg::VALUE_W-1:0]       cfg_data,
    output logic                                    done,
    output logic [tlba_pkg::HANDLE_W-1:0]           granted_handle,
    output logic [1:0]                              status,
    output logic [tlba_pkg::VALUE_W-1:0]            in_use_count
);

    localparam int VW      = tlba_pkg::VALUE_W;
    localparam int HW      = tlba_pkg::HANDLE_W;
    localparam int BW      = $clog2(WORD_BITS);
    localparam int NWORDS  = CAPACITY / WORD_BITS;
    localparam int NGROUPS = (NWORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int GAW     = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

    logic [WORD_BITS-1:0] used_mem [NWORDS];
    logic [WORD_BITS-1:0] sum_mem  [NGROUPS];

    logic [VW-1:0]        handle_limit_reg;
    logic [VW-1:0]        pending_limit_reg;
    logic [VW-1:0]        hint_reg;
    logic [VW-1:0]        held_reg;
    logic [WAW-1:0]       clr_idx_reg;
    logic                 done_reg;
    logic                 op_reg;
    logic [HW-1:0]        handle_reg;
    logic [VW-1:0]        g_reg;
    logic [VW-1:0]        w_reg;
    logic [WORD_BITS-1:0] word_rdata_reg;
    logic [WORD_BITS-1:0] sum_rdata_reg;
    logic [HW-1:0]        granted_reg;
    tlba_pkg::status_t    status_reg;

    logic [VW-1:0]        limit_eff;
    logic [VW-1:0]        handle_in;
    logic [VW-1:0]        handle_held;
    logic [VW-1:0]        load_src;
    logic [VW-1:0]        load_word;
    logic [VW-1:0]        load_group;
    logic [VW-1:0]        g_inc;
    logic [31:0]          w_scan;
    logic [31:0]          h_scan;
    logic [BW-1:0]        sfz_idx;
    logic                 sfz_none;
    logic [BW-1:0]        wfz_idx;
    logic                 wfz_none;
    logic                 rel_ok;
    logic                 limit_hit;
    logic [VW-1:0]        granted_val;
    logic [BW-1:0]        bit_pos;
    logic [WORD_BITS-1:0] word_bit;
    logic [WORD_BITS-1:0] sum_bit;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
    logic                 done_next;

    assign limit_eff   = (32'(handle_limit_reg) > CAPACITY) ? VW'(CAPACITY) : handle_limit_reg;
    assign handle_in   = VW'(handle);
    assign handle_held = VW'(handle_reg);
    assign load_src    = operation ? handle_in : hint_reg;
    assign load_word   = load_src >> BW;
    assign load_group  = load_src >> (2 * BW);
    assign g_inc       = g_reg + 1'b1;

    always_comb
    begin
        sfz_idx  = '0;
        sfz_none = &sum_rdata_reg;
        wfz_idx  = '0;
        wfz_none = &word_rdata_reg;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!sum_rdata_reg[i])
            begin
                sfz_idx = BW'(i);
            end
            if (!word_rdata_reg[i])
            begin
                wfz_idx = BW'(i);
            end
        end
    end

    assign w_scan    = (32'(g_reg) << BW) + 32'(sfz_idx);
    assign h_scan    = (32'(w_reg) << BW) + 32'(wfz_idx);
    assign limit_hit = (held_reg >= pending_limit_reg);
    assign rel_ok    = (handle_held < limit_eff) && word_rdata_reg[handle_reg[BW-1:0]];

    assign granted_val = cmd.use_scan ? VW'(h_scan) : hint_reg;
    assign bit_pos     = op_reg ? handle_reg[BW-1:0] : granted_val[BW-1:0];
    assign word_bit    = WORD_BITS'(1) << bit_pos;
    assign sum_bit     = WORD_BITS'(1) << w_reg[BW-1:0];
    assign set_word    = word_rdata_reg | word_bit;
    assign clr_word    = word_rdata_reg & ~word_bit;
    assign done_next   = cmd.release_item | cmd.grant | cmd.reject;

    always_comb
    begin
        stat            = '0;
        stat.clear_last = (clr_idx_reg == WAW'(NWORDS - 1));
        stat.is_release = op_reg;
        stat.limit_hit  = limit_hit;
        stat.hint_ok    = (hint_reg < limit_eff) && !word_rdata_reg[hint_reg[BW-1:0]];
        stat.group_out  = (32'(g_reg) >= NGROUPS)
                          || ((32'(g_reg) << (2 * BW)) >= 32'(limit_eff));
        stat.group_full = sfz_none;
        stat.word_out   = (w_scan >= NWORDS);
        stat.word_full  = wfz_none;
        stat.over_limit = (h_scan >= 32'(limit_eff));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_row)
        begin
            used_mem[clr_idx_reg] <= '0;
            if (32'(clr_idx_reg) < NGROUPS)
            begin
                sum_mem[GAW'(clr_idx_reg)] <= '0;
            end
        end
        else if (cmd.release_item && rel_ok)
        begin
            used_mem[WAW'(w_reg)] <= clr_word;
            sum_mem[GAW'(g_reg)]  <= sum_rdata_reg & ~sum_bit;
        end
        else if (cmd.grant)
        begin
            used_mem[WAW'(w_reg)] <= set_word;
            if (&set_word)
            begin
                sum_mem[GAW'(g_reg)] <= sum_rdata_reg | sum_bit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_rdata_reg <= used_mem[WAW'(load_word)];
        end
        else if (cmd.fetch_word)
        begin
            word_rdata_reg <= used_mem[WAW'(w_scan)];
        end
        if (cmd.load)
        begin
            sum_rdata_reg <= sum_mem[GAW'(load_group)];
        end
        else if (cmd.next_group)
        begin
            sum_rdata_reg <= sum_mem[GAW'(g_inc)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            handle_reg <= handle;
            g_reg      <= load_group;
            w_reg      <= load_word;
        end
        else
        begin
            if (cmd.next_group)
            begin
                g_reg <= g_inc;
            end
            if (cmd.fetch_word)
            begin
                w_reg <= VW'(w_scan);
            end
        end
        if (done_next)
        begin
            granted_reg <= cmd.grant ? HW'(granted_val) : '0;
            if (cmd.reject)
            begin
                status_reg <= cmd.reject_code;
            end
            else if (cmd.release_item && !rel_ok)
            begin
                status_reg <= tlba_pkg::STATUS_NO_HANDLE;
            end
            else
            begin
                status_reg <= tlba_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handle_limit_reg  <= tlba_pkg::LIMIT_RESET;
            pending_limit_reg <= tlba_pkg::LIMIT_RESET;
            hint_reg          <= '0;
            held_reg          <= '0;
            clr_idx_reg       <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (cmd.clear_row)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    tlba_pkg::REG_HANDLE_LIMIT:
                    begin
                        handle_limit_reg <= cfg_data;
                    end
                    tlba_pkg::REG_PENDING_LIMIT:
                    begin
                        pending_limit_reg <= cfg_data;
                    end
                    default:
                    begin
                        handle_limit_reg <= handle_limit_reg;
                    end
                endcase
            end
            if (cmd.grant)
            begin
                hint_reg <= granted_val + 1'b1;
                held_reg <= held_reg + 1'b1;
            end
            else if (cmd.release_item && rel_ok)
            begin
                if (handle_held < hint_reg)
                begin
                    hint_reg <= handle_held;
                end
                if (held_reg != '0)
                begin
                    held_reg <= held_reg - 1'b1;
                end
            end
        end
    end

    assign done           = done_reg;
    assign granted_handle = granted_reg;
    assign status         = status_reg;
    assign in_use_count   = held_reg;

`ifndef SYNTHESIS
    a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != tlba_pkg::STATUS_OK) |-> (granted_reg == '0))
        else $error("failed item reports a nonzero handle");

    a_grant_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |=> (held_reg == VW'($past(held_reg) + 1'b1)))
        else $error("grant did not raise the held count by one");

    a_grant_under_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> !limit_hit)
        else $error("grant issued with the pending limit reached");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_row |=> !done_reg)
        else $error("result produced during the clearing pass");
`endif

endmodule

`default_nettype wire
